// ----- rtl/mbq_pkg.sv -----
package mbq_pkg;

   localparam int CHANNELS       = 8;
   localparam int SAMPLE_BITS    = 24;
   localparam int CHAN_BITS      = 3;
   localparam int COEF_BITS      = 20;
   localparam int WORD_BITS      = 32;
   localparam int FRAC_BITS      = 16;
   localparam int FORM_BITS      = 2;
   localparam int ROW_BITS       = 4 * WORD_BITS;
   localparam int MEM_AW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PROD_BITS      = COEF_BITS + WORD_BITS;
   localparam int ACC_BITS       = PROD_BITS + 4;
   localparam int STEP_BITS      = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = COEF_BITS;

   localparam logic signed [COEF_BITS-1:0] COEF_UNITY    = COEF_BITS'(65536);
   localparam logic signed [COEF_BITS-1:0] COEF_A0_RESET = COEF_BITS'(65536);
   localparam logic signed [COEF_BITS-1:0] COEF_A1_RESET = COEF_BITS'(47841);
   localparam logic signed [COEF_BITS-1:0] COEF_A2_RESET = COEF_BITS'(65536);
   localparam logic signed [COEF_BITS-1:0] COEF_B1_RESET = COEF_BITS'(-51118);
   localparam logic signed [COEF_BITS-1:0] COEF_B2_RESET = COEF_BITS'(57672);

   typedef enum logic [FORM_BITS-1:0] {
      FORM_DIRECT,
      FORM_CANONICAL,
      FORM_TDIRECT,
      FORM_TCANONICAL
   } form_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STRUCTURE,
      CSR_COEF_A0,
      CSR_COEF_A1,
      CSR_COEF_A2,
      CSR_COEF_B1,
      CSR_COEF_B2
   } csr_index_type;

   typedef enum logic [2:0] {
      COEF_SEL_A0,
      COEF_SEL_A1,
      COEF_SEL_A2,
      COEF_SEL_B1,
      COEF_SEL_B2,
      COEF_SEL_ONE
   } coef_sel_type;

   typedef enum logic [2:0] {
      VAL_SEL_X,
      VAL_SEL_XZ1,
      VAL_SEL_XZ2,
      VAL_SEL_YZ1,
      VAL_SEL_YZ2,
      VAL_SEL_W,
      VAL_SEL_Y
   } val_sel_type;

   typedef enum logic [2:0] {
      DEST_NONE,
      DEST_W,
      DEST_Y,
      DEST_XZ1,
      DEST_XZ2,
      DEST_YZ1,
      DEST_YZ2
   } dest_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_LOAD,
      SEQ_RUN,
      SEQ_FINISH
   } seq_state_type;

   typedef struct packed {
      logic         mul;
      coef_sel_type coef;
      val_sel_type  val;
      logic         neg;
      logic         start;
      dest_type     dest;
      logic         last;
   } uop_type;

   localparam uop_type UOP_NOP = '{
      mul:   1'b0,
      coef:  COEF_SEL_ONE,
      val:   VAL_SEL_X,
      neg:   1'b0,
      start: 1'b0,
      dest:  DEST_NONE,
      last:  1'b0
   };

   typedef struct packed {
      logic    load;
      logic    row_valid;
      uop_type op;
   } mac_ctl_type;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [MEM_AW-1:0] addr;
   } mem_ctl_type;

   typedef struct packed {
      form_type                     form;
      logic signed [COEF_BITS-1:0] a0;
      logic signed [COEF_BITS-1:0] a1;
      logic signed [COEF_BITS-1:0] a2;
      logic signed [COEF_BITS-1:0] b1;
      logic signed [COEF_BITS-1:0] b2;
   } coef_set_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] yz2;
      logic signed [WORD_BITS-1:0] yz1;
      logic signed [WORD_BITS-1:0] xz2;
      logic signed [WORD_BITS-1:0] xz1;
   } row_type;

endpackage

// ----- rtl/mbq_req_if.sv -----
interface mbq_req_if;
   import mbq_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic [CHAN_BITS-1:0]          channel_in;

   modport source (output valid, output sample_in, output channel_in, input ready);
   modport sink (input valid, input sample_in, input channel_in, output ready);

endinterface

// ----- rtl/mbq_rsp_if.sv -----
interface mbq_rsp_if;
   import mbq_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic [CHAN_BITS-1:0]          channel_out;

   modport source (output valid, output sample_out, output channel_out, input ready);
   modport sink (input valid, input sample_out, input channel_out, output ready);

endinterface

// ----- rtl/multichannel_biquad_filter_core.sv -----
// Port       Dir  Word
// req_chan   in   sample_in (24 bits signed), channel_in (3 bits)
// rsp_chan   out  sample_out (24 bits signed), channel_out (3 bits)
// csr_*      in   write enable, register index (3 bits), write data (20 bits)
//
// One word is processed at a time. The time from one acceptance to the next depends
// on the form (direct, canonical, transposed direct or transposed canonical) and is
// set by the single shared 20 by 32 bit
// multiplier that takes one product per cycle, plus one RAM read and one write-back.
// The result waits in an output register; a stalled response holds the following
// word before its write-back, and so delays the next acceptance. Reset clears the per-channel valid bits, so all
// delay words read as zero without a clearing pass.
module multichannel_biquad_filter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   mbq_req_if.sink                              req_chan,
   mbq_rsp_if.source                            rsp_chan,
   input  logic                                 csr_write_en,
   input  logic [mbq_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mbq_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import mbq_pkg::*;

   coef_set_type                  coefs_ff;
   coef_set_type                  coefs_in;
   mac_ctl_type                   ctl;
   mem_ctl_type                   mem;
   row_type                       row_rd;
   row_type                       row_wr;
   logic signed [SAMPLE_BITS-1:0] x;
   logic signed [SAMPLE_BITS-1:0] y;

   always_comb begin
      coefs_in = coefs_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_STRUCTURE: coefs_in.form = form_type'(csr_wdata[FORM_BITS-1:0]);
            CSR_COEF_A0:   coefs_in.a0   = csr_wdata[COEF_BITS-1:0];
            CSR_COEF_A1:   coefs_in.a1   = csr_wdata[COEF_BITS-1:0];
            CSR_COEF_A2:   coefs_in.a2   = csr_wdata[COEF_BITS-1:0];
            CSR_COEF_B1:   coefs_in.b1   = csr_wdata[COEF_BITS-1:0];
            CSR_COEF_B2:   coefs_in.b2   = csr_wdata[COEF_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff <= '{
            form: FORM_DIRECT,
            a0:   COEF_A0_RESET,
            a1:   COEF_A1_RESET,
            a2:   COEF_A2_RESET,
            b1:   COEF_B1_RESET,
            b2:   COEF_B2_RESET
         };
      end else begin
         coefs_ff <= coefs_in;
      end
   end

   mbq_seq u_seq (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan),
      .form  (coefs_ff.form),
      .y     (y),
      .ctl   (ctl),
      .mem   (mem),
      .x     (x)
   );

   mbq_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .coefs  (coefs_ff),
      .x      (x),
      .row_rd (row_rd),
      .row_wr (row_wr),
      .y      (y)
   );

   mbq_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (CHANNELS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.addr),
      .wr_data (row_wr),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.addr),
      .rd_data (row_rd)
   );

endmodule

// ----- rtl/mbq_ram.sv -----
module mbq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/mbq_mac.sv -----
module mbq_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mbq_pkg::mac_ctl_type                  ctl,
   input  mbq_pkg::coef_set_type                 coefs,
   input  logic signed [mbq_pkg::SAMPLE_BITS-1:0] x,
   input  mbq_pkg::row_type                      row_rd,
   output mbq_pkg::row_type                      row_wr,
   output logic signed [mbq_pkg::SAMPLE_BITS-1:0] y
);
   import mbq_pkg::*;

   localparam int RND_BITS = ACC_BITS - FRAC_BITS;
   localparam logic signed [ACC_BITS-1:0] RND_HALF = ACC_BITS'(2 ** (FRAC_BITS - 1));

   row_type                       old_ff;
   logic signed [WORD_BITS-1:0]   w_ff;
   logic signed [WORD_BITS-1:0]   xz1_ff;
   logic signed [WORD_BITS-1:0]   xz2_ff;
   logic signed [WORD_BITS-1:0]   yz1_ff;
   logic signed [WORD_BITS-1:0]   yz2_ff;
   logic signed [SAMPLE_BITS-1:0] y_ff;
   logic signed [COEF_BITS-1:0]   coef;
   logic signed [WORD_BITS-1:0]   val;
   logic signed [WORD_BITS-1:0]   x_word;
   logic signed [WORD_BITS-1:0]   y_word;
   logic signed [PROD_BITS-1:0]   prod_in;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic                          acc_en_ff;
   logic                          acc_start_ff;
   logic                          acc_neg_ff;
   logic signed [ACC_BITS-1:0]    addend;
   logic signed [ACC_BITS-1:0]    acc_in;
   logic signed [ACC_BITS-1:0]    acc_ff;
   logic signed [ACC_BITS-1:0]    rnd_sum;
   logic signed [RND_BITS-1:0]    rnd_val;
   logic signed [WORD_BITS-1:0]   word_val;
   logic signed [SAMPLE_BITS-1:0] out_val;

   assign x_word = WORD_BITS'(x);
   assign y_word = WORD_BITS'(y_ff);
   assign y      = y_ff;

   always_comb begin
      unique case (ctl.op.coef)
         COEF_SEL_A0: coef = coefs.a0;
         COEF_SEL_A1: coef = coefs.a1;
         COEF_SEL_A2: coef = coefs.a2;
         COEF_SEL_B1: coef = coefs.b1;
         COEF_SEL_B2: coef = coefs.b2;
         default:     coef = COEF_UNITY;
      endcase
   end

   always_comb begin
      unique case (ctl.op.val)
         VAL_SEL_X:   val = x_word;
         VAL_SEL_XZ1: val = old_ff.xz1;
         VAL_SEL_XZ2: val = old_ff.xz2;
         VAL_SEL_YZ1: val = old_ff.yz1;
         VAL_SEL_YZ2: val = old_ff.yz2;
         VAL_SEL_W:   val = w_ff;
         VAL_SEL_Y:   val = y_word;
         default:     val = x_word;
      endcase
   end

   assign prod_in = coef * val;

   always_comb begin
      addend = ACC_BITS'(prod_ff);
      if (acc_neg_ff) begin
         addend = -ACC_BITS'(prod_ff);
      end
      acc_in = acc_start_ff ? addend : acc_ff + addend;
   end

   // The sum is rounded to nearest, ties toward positive, then clipped.
   always_comb begin
      rnd_sum = acc_ff + RND_HALF;
      rnd_val = rnd_sum[ACC_BITS-1:FRAC_BITS];
      if (rnd_val[RND_BITS-1:WORD_BITS-1] ==
          {(RND_BITS-WORD_BITS+1){rnd_val[RND_BITS-1]}}) begin
         word_val = rnd_val[WORD_BITS-1:0];
      end else if (rnd_val[RND_BITS-1]) begin
         word_val = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
         word_val = {1'b0, {(WORD_BITS-1){1'b1}}};
      end
      if (rnd_val[RND_BITS-1:SAMPLE_BITS-1] ==
          {(RND_BITS-SAMPLE_BITS+1){rnd_val[RND_BITS-1]}}) begin
         out_val = rnd_val[SAMPLE_BITS-1:0];
      end else if (rnd_val[RND_BITS-1]) begin
         out_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         out_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_en_ff    <= 1'b0;
         acc_start_ff <= 1'b0;
         acc_neg_ff   <= 1'b0;
      end else begin
         acc_en_ff    <= ctl.op.mul;
         acc_start_ff <= ctl.op.start;
         acc_neg_ff   <= ctl.op.neg;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (acc_en_ff) begin
         acc_ff <= acc_in;
      end
      if (ctl.load) begin
         old_ff <= ctl.row_valid ? row_rd : '0;
      end
      unique case (ctl.op.dest)
         DEST_W:   w_ff   <= word_val;
         DEST_Y:   y_ff   <= out_val;
         DEST_XZ1: xz1_ff <= word_val;
         DEST_XZ2: xz2_ff <= word_val;
         DEST_YZ1: yz1_ff <= word_val;
         DEST_YZ2: yz2_ff <= word_val;
         default: begin
         end
      endcase
   end

   always_comb begin
      row_wr = old_ff;
      unique case (coefs.form)
         FORM_DIRECT: begin
            row_wr.xz1 = x_word;
            row_wr.xz2 = old_ff.xz1;
            row_wr.yz1 = y_word;
            row_wr.yz2 = old_ff.yz1;
         end
         FORM_CANONICAL: begin
            row_wr.xz1 = w_ff;
            row_wr.xz2 = old_ff.xz1;
         end
         FORM_TDIRECT: begin
            row_wr.xz1 = xz1_ff;
            row_wr.xz2 = xz2_ff;
            row_wr.yz1 = yz1_ff;
            row_wr.yz2 = yz2_ff;
         end
         FORM_TCANONICAL: begin
            row_wr.xz1 = xz1_ff;
            row_wr.xz2 = xz2_ff;
         end
      endcase
   end

endmodule

// ----- rtl/mbq_seq.sv -----
module mbq_seq (
   input  logic                                  clock,
   input  logic                                  reset,
   mbq_req_if.sink                               req,
   mbq_rsp_if.source                             rsp,
   input  mbq_pkg::form_type                     form,
   input  logic signed [mbq_pkg::SAMPLE_BITS-1:0] y,
   output mbq_pkg::mac_ctl_type                  ctl,
   output mbq_pkg::mem_ctl_type                  mem,
   output logic signed [mbq_pkg::SAMPLE_BITS-1:0] x
);
   import mbq_pkg::*;

   function automatic uop_type mac_op(coef_sel_type c, val_sel_type v, logic neg,
                                      logic start);
      uop_type op;
      op       = UOP_NOP;
      op.mul   = 1'b1;
      op.coef  = c;
      op.val   = v;
      op.neg   = neg;
      op.start = start;
      return op;
   endfunction

   // A product issued in one step lands in the accumulator in the next step, and a
   // step that commits reads the accumulator before that step's own update.
   function automatic uop_type ucode(form_type f, logic [STEP_BITS-1:0] step);
      uop_type op;
      op = UOP_NOP;
      unique case (f)
         FORM_DIRECT: begin
            unique case (step)
               0: op = mac_op(COEF_SEL_A0, VAL_SEL_X, 1'b0, 1'b1);
               1: op = mac_op(COEF_SEL_A1, VAL_SEL_XZ1, 1'b0, 1'b0);
               2: op = mac_op(COEF_SEL_A2, VAL_SEL_XZ2, 1'b0, 1'b0);
               3: op = mac_op(COEF_SEL_B1, VAL_SEL_YZ1, 1'b1, 1'b0);
               4: op = mac_op(COEF_SEL_B2, VAL_SEL_YZ2, 1'b1, 1'b0);
               6: begin
                  op.dest = DEST_Y;
                  op.last = 1'b1;
               end
               default: op = UOP_NOP;
            endcase
         end
         FORM_CANONICAL: begin
            unique case (step)
               0: op = mac_op(COEF_SEL_ONE, VAL_SEL_X, 1'b0, 1'b1);
               1: op = mac_op(COEF_SEL_B1, VAL_SEL_XZ1, 1'b1, 1'b0);
               2: op = mac_op(COEF_SEL_B2, VAL_SEL_XZ2, 1'b1, 1'b0);
               3: op = mac_op(COEF_SEL_A1, VAL_SEL_XZ1, 1'b0, 1'b1);
               4: begin
                  op      = mac_op(COEF_SEL_A2, VAL_SEL_XZ2, 1'b0, 1'b0);
                  op.dest = DEST_W;
               end
               5: op = mac_op(COEF_SEL_A0, VAL_SEL_W, 1'b0, 1'b0);
               7: begin
                  op.dest = DEST_Y;
                  op.last = 1'b1;
               end
               default: op = UOP_NOP;
            endcase
         end
         FORM_TDIRECT: begin
            unique case (step)
               0: op = mac_op(COEF_SEL_ONE, VAL_SEL_X, 1'b0, 1'b1);
               1: op = mac_op(COEF_SEL_ONE, VAL_SEL_YZ1, 1'b0, 1'b0);
               2: op = mac_op(COEF_SEL_ONE, VAL_SEL_XZ1, 1'b0, 1'b1);
               3: op.dest = DEST_W;
               4: op = mac_op(COEF_SEL_A0, VAL_SEL_W, 1'b0, 1'b0);
               5: op = mac_op(COEF_SEL_ONE, VAL_SEL_YZ2, 1'b0, 1'b1);
               6: begin
                  op      = mac_op(COEF_SEL_B1, VAL_SEL_W, 1'b1, 1'b0);
                  op.dest = DEST_Y;
               end
               7: op = mac_op(COEF_SEL_B2, VAL_SEL_W, 1'b1, 1'b1);
               8: begin
                  op      = mac_op(COEF_SEL_ONE, VAL_SEL_XZ2, 1'b0, 1'b1);
                  op.dest = DEST_YZ1;
               end
               9: begin
                  op      = mac_op(COEF_SEL_A1, VAL_SEL_W, 1'b0, 1'b0);
                  op.dest = DEST_YZ2;
               end
               10: op = mac_op(COEF_SEL_A2, VAL_SEL_W, 1'b0, 1'b1);
               11: op.dest = DEST_XZ1;
               12: begin
                  op.dest = DEST_XZ2;
                  op.last = 1'b1;
               end
               default: op = UOP_NOP;
            endcase
         end
         FORM_TCANONICAL: begin
            unique case (step)
               0: op = mac_op(COEF_SEL_A0, VAL_SEL_X, 1'b0, 1'b1);
               1: op = mac_op(COEF_SEL_ONE, VAL_SEL_XZ1, 1'b0, 1'b0);
               2: op = mac_op(COEF_SEL_A1, VAL_SEL_X, 1'b0, 1'b1);
               3: begin
                  op      = mac_op(COEF_SEL_ONE, VAL_SEL_XZ2, 1'b0, 1'b0);
                  op.dest = DEST_Y;
               end
               4: op = mac_op(COEF_SEL_B1, VAL_SEL_Y, 1'b1, 1'b0);
               5: op = mac_op(COEF_SEL_A2, VAL_SEL_X, 1'b0, 1'b1);
               6: begin
                  op      = mac_op(COEF_SEL_B2, VAL_SEL_Y, 1'b1, 1'b0);
                  op.dest = DEST_XZ1;
               end
               8: begin
                  op.dest = DEST_XZ2;
                  op.last = 1'b1;
               end
               default: op = UOP_NOP;
            endcase
         end
      endcase
      return op;
   endfunction

   seq_state_type                 state_ff;
   seq_state_type                 state_in;
   logic [STEP_BITS-1:0]          step_ff;
   logic [STEP_BITS-1:0]          step_in;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic [CHAN_BITS-1:0]          ch_ff;
   logic [CHANNELS-1:0]           valid_ff;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic [CHAN_BITS-1:0]          rsp_channel_ff;
   logic [MEM_AW-1:0]             ch_addr;
   logic                          chan_ok;
   logic                          accept;
   logic                          finish;
   uop_type                       uop;

   assign ch_addr = MEM_AW'(ch_ff);
   assign chan_ok = int'(ch_ff) < CHANNELS;
   assign uop     = ucode(form, step_ff);
   assign x       = x_ff;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.sample_out  = rsp_sample_ff;
   assign rsp.channel_out = rsp_channel_ff;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      req.ready     = 1'b0;
      accept        = 1'b0;
      finish        = 1'b0;
      ctl.load      = 1'b0;
      ctl.row_valid = 1'b0;
      ctl.op        = UOP_NOP;
      mem.rd_en     = 1'b0;
      mem.wr_en     = 1'b0;
      mem.addr      = ch_addr;
      unique case (state_ff)
         SEQ_IDLE: begin
            req.ready = 1'b1;
            mem.addr  = MEM_AW'(req.channel_in);
            if (req.valid) begin
               accept    = 1'b1;
               mem.rd_en = 1'b1;
               state_in  = SEQ_LOAD;
            end
         end
         SEQ_LOAD: begin
            ctl.load      = 1'b1;
            ctl.row_valid = chan_ok && valid_ff[ch_addr];
            step_in       = '0;
            state_in      = SEQ_RUN;
         end
         SEQ_RUN: begin
            ctl.op = uop;
            if (uop.last) begin
               state_in = SEQ_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         SEQ_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               finish    = 1'b1;
               mem.wr_en = chan_ok;
               state_in  = SEQ_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         step_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (finish && chan_ok) begin
            valid_ff[ch_addr] <= 1'b1;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff  <= req.sample_in;
         ch_ff <= req.channel_in;
      end
      if (finish) begin
         rsp_sample_ff  <= chan_ok ? y : '0;
         rsp_channel_ff <= ch_ff;
      end
   end

endmodule

// ----- sim/tb.sv -----
module tb;
   import mbq_pkg::*;

   localparam int QUIET_CYCLES = 40;
   localparam int RANDOM_WORDS = 1600;
   localparam int DIRECTED_ROWS = 39;
   localparam int REPORT_LIMIT = 10;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_HI = 3'd7;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [CSR_DATA_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam logic [CSR_DATA_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [CHAN_BITS-1:0]          channel;
   } filt_word_type;

   typedef enum logic {
      ROW_SAMPLE,
      ROW_REG
   } row_kind_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic [CSR_INDEX_BITS-1:0]     reg_index;
      logic [CSR_DATA_BITS-1:0]      reg_value;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [CHAN_BITS-1:0]          channel;
      logic                          known;
      logic signed [SAMPLE_BITS-1:0] known_out;
   } stim_row_type;

   typedef enum int {
      COEFS_EXTREME,
      COEFS_SMALL,
      COEFS_RESET,
      COEFS_RANDOM
   } coef_style_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   mbq_req_if req_chan ();
   mbq_rsp_if rsp_chan ();

   multichannel_biquad_filter_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   coef_set_type  filt_coefs;
   row_type       chan_rows [CHANNELS];
   filt_word_type pending_outputs [$];
   stim_row_type  directed_rows [DIRECTED_ROWS];
   int unsigned   fail_count = 0;
   bit            req_steady = 1'b0;
   bit            rsp_steady = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp(input longint v, input int unsigned bits);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   // Round a Q.16 accumulator to sample units, then saturate to the given width.
   function automatic longint rescale(input longint acc, input int unsigned bits);
      return clamp((acc + 64'sd32768) >>> FRAC_BITS, bits);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] biquad_step(
      input logic signed [SAMPLE_BITS-1:0] x_in,
      input logic [CHAN_BITS-1:0]          ch
   );
      longint  x, a0, a1, a2, b1, b2;
      longint  xz1, xz2, yz1, yz2, w, y;
      row_type row;
      y = 0;
      if (int'(ch) < CHANNELS) begin
         row = chan_rows[ch];
         x   = x_in;
         a0  = $signed(filt_coefs.a0);
         a1  = $signed(filt_coefs.a1);
         a2  = $signed(filt_coefs.a2);
         b1  = $signed(filt_coefs.b1);
         b2  = $signed(filt_coefs.b2);
         xz1 = $signed(row.xz1);
         xz2 = $signed(row.xz2);
         yz1 = $signed(row.yz1);
         yz2 = $signed(row.yz2);
         case (filt_coefs.form)
            FORM_DIRECT: begin
               y = rescale(a0 * x + a1 * xz1 + a2 * xz2 - b1 * yz1 - b2 * yz2, SAMPLE_BITS);
               row.xz2 = row.xz1;
               row.xz1 = WORD_BITS'(x);
               row.yz2 = row.yz1;
               row.yz1 = WORD_BITS'(y);
            end
            FORM_CANONICAL: begin
               w = rescale((x <<< FRAC_BITS) - b1 * xz1 - b2 * xz2, WORD_BITS);
               y = rescale(a0 * w + a1 * xz1 + a2 * xz2, SAMPLE_BITS);
               row.xz2 = row.xz1;
               row.xz1 = WORD_BITS'(w);
            end
            FORM_TDIRECT: begin
               w = clamp(x + yz1, WORD_BITS);
               y = rescale(a0 * w + (xz1 <<< FRAC_BITS), SAMPLE_BITS);
               row.yz1 = WORD_BITS'(rescale((yz2 <<< FRAC_BITS) - b1 * w, WORD_BITS));
               row.yz2 = WORD_BITS'(rescale(-b2 * w, WORD_BITS));
               row.xz1 = WORD_BITS'(rescale((xz2 <<< FRAC_BITS) + a1 * w, WORD_BITS));
               row.xz2 = WORD_BITS'(rescale(a2 * w, WORD_BITS));
            end
            default: begin
               // The feedback terms use the output after saturation.
               y = rescale(a0 * x + (xz1 <<< FRAC_BITS), SAMPLE_BITS);
               row.xz1 = WORD_BITS'(rescale(a1 * x - b1 * y + (xz2 <<< FRAC_BITS), WORD_BITS));
               row.xz2 = WORD_BITS'(rescale(a2 * x - b2 * y, WORD_BITS));
            end
         endcase
         chan_rows[ch] = row;
      end
      return SAMPLE_BITS'(y);
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return SAMPLE_MAX;
      if (r == 1) return SAMPLE_MIN;
      if (r == 2) return SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32);
      return SAMPLE_BITS'($urandom);
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_coef(
      input coef_style_type            style,
      input logic [CSR_INDEX_BITS-1:0] idx
   );
      case (style)
         COEFS_EXTREME: return ($urandom_range(0, 1) != 0) ? COEF_MAX : COEF_MIN;
         COEFS_SMALL:   return CSR_DATA_BITS'(int'($urandom_range(0, 60000)) - 30000);
         COEFS_RESET: begin
            case (idx)
               CSR_COEF_A0: return COEF_A0_RESET;
               CSR_COEF_A1: return COEF_A1_RESET;
               CSR_COEF_A2: return COEF_A2_RESET;
               CSR_COEF_B1: return COEF_B1_RESET;
               default:     return COEF_B2_RESET;
            endcase
         end
         default: return CSR_DATA_BITS'($urandom);
      endcase
   endfunction

   task automatic write_reg(
      input logic [CSR_INDEX_BITS-1:0] idx,
      input logic [CSR_DATA_BITS-1:0]  value
   );
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      case (idx)
         CSR_STRUCTURE: filt_coefs.form = form_type'(value[FORM_BITS-1:0]);
         CSR_COEF_A0:   filt_coefs.a0 = value;
         CSR_COEF_A1:   filt_coefs.a1 = value;
         CSR_COEF_A2:   filt_coefs.a2 = value;
         CSR_COEF_B1:   filt_coefs.b1 = value;
         CSR_COEF_B2:   filt_coefs.b2 = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic send_word(
      input logic signed [SAMPLE_BITS-1:0] smp,
      input logic [CHAN_BITS-1:0]          ch,
      input logic                          known,
      input logic signed [SAMPLE_BITS-1:0] known_out
   );
      int unsigned   gap;
      filt_word_type want;
      gap = req_steady ? 0 : pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.sample_in  <= smp;
      req_chan.channel_in <= ch;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      want.channel = ch;
      want.sample  = biquad_step(smp, ch);
      if (known) want.sample = known_out;
      pending_outputs.push_back(want);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   initial begin : rsp_pacing
      int unsigned stall_left;
      int unsigned n;
      rsp_chan.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            n = rsp_steady ? 0 : pick_gap();
            if (n == 0) begin
               rsp_chan.ready <= 1'b1;
            end else begin
               rsp_chan.ready <= 1'b0;
               stall_left = n - 1;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      filt_word_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_outputs.size() == 0) begin
            log_failure($sformatf("unexpected output word: sample %0d channel %0d",
                                  rsp_chan.sample_out, rsp_chan.channel_out));
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_chan.sample_out !== want.sample || rsp_chan.channel_out !== want.channel) begin
               log_failure($sformatf(
                  "output word mismatch: expected sample %0d channel %0d, got sample %0d channel %0d",
                  want.sample, want.channel, rsp_chan.sample_out, rsp_chan.channel_out));
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned               sent;
      int unsigned               phase_len;
      coef_style_type            style;
      logic [CSR_INDEX_BITS-1:0] reg_idx;
      logic [CHAN_BITS-1:0]      focus_ch;
      logic [CHAN_BITS-1:0]      ch;

      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.sample_in  = '0;
      req_chan.channel_in = '0;
      csr_write_en        = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;

      filt_coefs.form = FORM_DIRECT;
      filt_coefs.a0   = COEF_A0_RESET;
      filt_coefs.a1   = COEF_A1_RESET;
      filt_coefs.a2   = COEF_A2_RESET;
      filt_coefs.b1   = COEF_B1_RESET;
      filt_coefs.b2   = COEF_B2_RESET;
      foreach (chan_rows[i]) chan_rows[i] = '0;

      // With the reset coefficients a0 is unity, so a fresh channel passes its first
      // sample through; with a0 at either extreme a full-scale first sample saturates.
      directed_rows = '{
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, SAMPLE_MAX, 3'd0, 1'b1, SAMPLE_MAX},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, SAMPLE_MIN, 3'd1, 1'b1, SAMPLE_MIN},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, '0, 3'd2, 1'b1, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, 24'sd1, 3'd0, 1'b0, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, -24'sd1, 3'd7, 1'b1, -24'sd1},
         '{ROW_REG, CSR_COEF_A0, COEF_MIN, '0, 3'd0, 1'b0, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, SAMPLE_MAX, 3'd3, 1'b1, SAMPLE_MIN},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, SAMPLE_MIN, 3'd4, 1'b1, SAMPLE_MAX},
         '{ROW_REG, CSR_COEF_A0, COEF_MAX, '0, 3'd0, 1'b0, '0},
         '{ROW_REG, CSR_COEF_A1, COEF_MIN, '0, 3'd0, 1'b0, '0},
         '{ROW_REG, CSR_COEF_A2, COEF_MAX, '0, 3'd0, 1'b0, '0},
         '{ROW_REG, CSR_COEF_B1, COEF_MIN, '0, 3'd0, 1'b0, '0},
         '{ROW_REG, CSR_COEF_B2, COEF_MAX, '0, 3'd0, 1'b0, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, SAMPLE_MAX, 3'd5, 1'b0, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, SAMPLE_MIN, 3'd5, 1'b0, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, 24'sh2AAAAA, 3'd3, 1'b0, '0},
         '{ROW_REG, CSR_STRUCTURE, 20'(FORM_CANONICAL), '0, 3'd0, 1'b0, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, SAMPLE_MAX, 3'd5, 1'b0, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, SAMPLE_MIN, 3'd6, 1'b0, '0},
         '{ROW_REG, CSR_STRUCTURE, 20'(FORM_TDIRECT), '0, 3'd0, 1'b0, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, SAMPLE_MIN, 3'd5, 1'b0, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, SAMPLE_MAX, 3'd6, 1'b0, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, -24'sh555556, 3'd0, 1'b0, '0},
         '{ROW_REG, CSR_STRUCTURE, 20'(FORM_TCANONICAL), '0, 3'd0, 1'b0, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, SAMPLE_MAX, 3'd5, 1'b0, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, SAMPLE_MIN, 3'd1, 1'b0, '0},
         '{ROW_REG, CSR_UNMAPPED_LO, 20'hFFFFF, '0, 3'd0, 1'b0, '0},
         '{ROW_REG, CSR_UNMAPPED_HI, 20'h12345, '0, 3'd0, 1'b0, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, 24'sd1000, 3'd2, 1'b0, '0},
         '{ROW_REG, CSR_STRUCTURE, 20'hFFFFC, '0, 3'd0, 1'b0, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, -24'sd1000, 3'd5, 1'b0, '0},
         '{ROW_REG, CSR_COEF_A0, COEF_A0_RESET, '0, 3'd0, 1'b0, '0},
         '{ROW_REG, CSR_COEF_A1, COEF_A1_RESET, '0, 3'd0, 1'b0, '0},
         '{ROW_REG, CSR_COEF_A2, COEF_A2_RESET, '0, 3'd0, 1'b0, '0},
         '{ROW_REG, CSR_COEF_B1, COEF_B1_RESET, '0, 3'd0, 1'b0, '0},
         '{ROW_REG, CSR_COEF_B2, COEF_B2_RESET, '0, 3'd0, 1'b0, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, SAMPLE_MAX, 3'd7, 1'b0, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, SAMPLE_MIN, 3'd7, 1'b0, '0},
         '{ROW_SAMPLE, CSR_STRUCTURE, '0, 24'sh123456, 3'd6, 1'b0, '0}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REG) begin
            wait_quiet();
            write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_word(directed_rows[i].sample, directed_rows[i].channel,
                      directed_rows[i].known, directed_rows[i].known_out);
         end
      end

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         wait_quiet();
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         style = coef_style_type'($urandom_range(0, 3));
         write_reg(CSR_STRUCTURE, CSR_DATA_BITS'($urandom));
         for (reg_idx = CSR_COEF_A0; reg_idx <= CSR_COEF_B2; reg_idx++) begin
            write_reg(reg_idx, pick_coef(style, reg_idx));
         end
         if ($urandom_range(0, 3) == 0) begin
            write_reg(($urandom_range(0, 1) != 0) ? CSR_UNMAPPED_LO : CSR_UNMAPPED_HI,
                      CSR_DATA_BITS'($urandom));
         end
         focus_ch  = CHAN_BITS'($urandom);
         phase_len = $urandom_range(40, 160);
         if (phase_len > RANDOM_WORDS - sent) begin
            phase_len = RANDOM_WORDS - sent;
         end
         repeat (phase_len) begin
            ch = ($urandom_range(0, 2) == 0) ? focus_ch : CHAN_BITS'($urandom);
            send_word(pick_sample(), ch, 1'b0, '0);
            sent++;
         end
      end

      wait_quiet();
      if (fail_count == 0) begin
         $display("multichannel_biquad_filter_core regression: pass");
      end else begin
         $display("multichannel_biquad_filter_core regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #10000000;
      $display("multichannel_biquad_filter_core regression: fail");
      $finish;
   end

endmodule
